FILE: sv/agt_pkg.sv
// Package for the arm gravity torque block: field structs, sizes, quarter-wave sine table
// and the angle and rounding helpers shared by the front and back sections.
// No dependencies.
package agt_pkg;

	localparam int POSITION_SPAN    = 65536;
	localparam int SINE_TABLE_DEPTH = 256;
	localparam int TURN_STEPS       = 4 * SINE_TABLE_DEPTH;
	localparam int POS_W            = $clog2(POSITION_SPAN);
	localparam int IDX_W            = $clog2(TURN_STEPS);
	localparam int TAB_AW           = $clog2(SINE_TABLE_DEPTH) + 1;
	localparam int TRIG_W           = 18;
	localparam int Q_W              = 55;
	localparam int SCALED_W         = 66;
	localparam int QUEUE_DEPTH      = 4;
	localparam int QUEUE_AW         = $clog2(QUEUE_DEPTH);
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [2:0] {
		REG_FORE_MASS  = 3'd0,
		REG_FORE_COG   = 3'd1,
		REG_FORE_SPAN  = 3'd2,
		REG_GRIP_MASS  = 3'd3,
		REG_GRIP_COG   = 3'd4,
		REG_UPPER_MASS = 3'd5,
		REG_UPPER_COG  = 3'd6,
		REG_UPPER_SPAN = 3'd7
	} cfg_reg_e;

	typedef struct packed {
		logic [15:0] shoulder_pos;
		logic [15:0] elbow_pos;
		logic [15:0] wrist_roll_pos;
		logic [15:0] wrist_pitch_pos;
	} pos_t;

	typedef struct packed {
		logic signed [31:0] shoulder_torque;
		logic signed [31:0] elbow_torque;
		logic signed [31:0] wrist_roll_torque;
		logic signed [31:0] wrist_pitch_torque;
	} torque_t;

	typedef struct packed {
		logic [15:0] fore_mass;
		logic [15:0] fore_cog;
		logic [15:0] fore_span;
		logic [15:0] grip_mass;
		logic [15:0] grip_cog;
		logic [15:0] upper_mass;
		logic [15:0] upper_cog;
		logic [15:0] upper_span;
	} cfg_t;

	typedef logic signed [TRIG_W-1:0] trig_val_t;

	typedef struct packed {
		trig_val_t c1;
		trig_val_t c13;
		trig_val_t c4;
		trig_val_t s4;
		trig_val_t s5;
		trig_val_t c135;
	} trig_t;

	typedef logic [16:0] sine_tab_t [0:SINE_TABLE_DEPTH];

	// Q30 Taylor series through x^17, rounded to Q16
	function automatic sine_tab_t build_sine_tab();
		sine_tab_t tab;
		longint unsigned x;
		longint unsigned term;
		longint acc;
		longint v;
		for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
			x = (HALF_PI_Q30 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
			term = x;
			acc = longint'(x);
			for (int n = 1; n <= 8; n++) begin
				term = (term * x) >> 30;
				term = (term * x) >> 30;
				term = term / 64'((2 * n) * (2 * n + 1));
				if ((n % 2) == 1)
					acc = acc - longint'(term);
				else
					acc = acc + longint'(term);
			end
			if (acc < 0)
				v = 0;
			else
				v = (acc + 8192) >>> 14;
			if (v > 65536)
				v = 65536;
			tab[k] = 17'(v);
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine_tab();

	function automatic logic [POS_W-1:0] reduce_pos(input logic [15:0] p);
		return POS_W'(17'(p) % 17'(POSITION_SPAN));
	endfunction

	function automatic logic [POS_W-1:0] add_pos(input logic [POS_W-1:0] a,
			input logic [POS_W-1:0] b);
		logic [POS_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (POS_W+1)'(POSITION_SPAN))
			s = s - (POS_W+1)'(POSITION_SPAN);
		return POS_W'(s);
	endfunction

	function automatic logic [IDX_W-1:0] angle_index(input logic [POS_W-1:0] p);
		logic [31:0] t;
		t = 32'(p) * 32'(TURN_STEPS) + 32'(POSITION_SPAN / 2);
		return IDX_W'((t / 32'(POSITION_SPAN)) % 32'(TURN_STEPS));
	endfunction

	function automatic logic [IDX_W-1:0] cos_index(input logic [IDX_W-1:0] i);
		logic [IDX_W:0] s;
		s = {1'b0, i} + (IDX_W+1)'(SINE_TABLE_DEPTH);
		return IDX_W'(s % (IDX_W+1)'(TURN_STEPS));
	endfunction

	function automatic trig_val_t sine_of(input logic [IDX_W-1:0] i);
		logic [1:0] q;
		logic [TAB_AW-1:0] r;
		logic [16:0] v;
		q = 2'(i / IDX_W'(SINE_TABLE_DEPTH));
		r = TAB_AW'(i % IDX_W'(SINE_TABLE_DEPTH));
		if (q[0])
			v = SINE_TAB[TAB_AW'(SINE_TABLE_DEPTH) - r];
		else
			v = SINE_TAB[r];
		if (q[1])
			return -$signed({1'b0, v});
		return $signed({1'b0, v});
	endfunction

	// Q32 product back to Q16, half away from zero
	function automatic trig_val_t rnd16(input logic signed [35:0] v);
		logic signed [35:0] t;
		if (!v[35])
			t = (v + 36'sd32768) >>> 16;
		else
			t = -((-v + 36'sd32768) >>> 16);
		return TRIG_W'(t);
	endfunction

	function automatic logic signed [31:0] to_mnm(input logic signed [SCALED_W-1:0] v);
		logic signed [SCALED_W-1:0] t;
		if (!v[SCALED_W-1])
			t = (v + (SCALED_W'(1) <<< 31)) >>> 32;
		else
			t = -((-v + (SCALED_W'(1) <<< 31)) >>> 32);
		if (t > SCALED_W'(64'sd2147483647))
			return 32'sh7fffffff;
		if (t < -(SCALED_W'(64'sd2147483648)))
			return 32'sh80000000;
		return 32'(t);
	endfunction

endpackage

FILE: sv/agt_front.sv
// Front section: joint angle sums, table indexes and sine/cosine lookup, two stages.
// Depends on agt_pkg.
module agt_front
	import agt_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  take,
	input  pos_t  positions,
	output logic  push,
	output trig_t trig
);

	logic [IDX_W-1:0] i1_s1, i13_s1, i4_s1, i5_s1, i135_s1;
	logic             valid_s1, valid_s2;
	trig_t            trig_s2;
	logic [POS_W-1:0] p1, p3, p4, p5, p13, p135;

	always_comb begin
		p1   = reduce_pos(positions.shoulder_pos);
		p3   = reduce_pos(positions.elbow_pos);
		p4   = reduce_pos(positions.wrist_roll_pos);
		p5   = reduce_pos(positions.wrist_pitch_pos);
		p13  = add_pos(p1, p3);
		p135 = add_pos(p13, p5);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= take;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		i1_s1   <= angle_index(p1);
		i13_s1  <= angle_index(p13);
		i4_s1   <= angle_index(p4);
		i5_s1   <= angle_index(p5);
		i135_s1 <= angle_index(p135);
		trig_s2.c1   <= sine_of(cos_index(i1_s1));
		trig_s2.c13  <= sine_of(cos_index(i13_s1));
		trig_s2.c4   <= sine_of(cos_index(i4_s1));
		trig_s2.s4   <= sine_of(i4_s1);
		trig_s2.s5   <= sine_of(i5_s1);
		trig_s2.c135 <= sine_of(cos_index(i135_s1));
	end

	assign push = valid_s2;
	assign trig = trig_s2;

endmodule

FILE: sv/agt_queue.sv
// Short queue of trig words between front and back sections.
// Depends on agt_pkg.
module agt_queue
	import agt_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  trig_t wdata,
	input  logic  pop,
	output logic  nonempty,
	output logic  almost_full,
	output trig_t rdata
);

	trig_t               mem_q [0:QUEUE_DEPTH-1];
	logic [QUEUE_AW-1:0] wr_q, rd_q;
	logic [QUEUE_AW:0]   count_q;
	logic                do_pop;

	assign nonempty    = (count_q != '0);
	assign almost_full = (count_q >= (QUEUE_AW+1)'(QUEUE_DEPTH - 1));
	assign do_pop      = pop && nonempty;
	assign rdata       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (do_pop)
				rd_q <= rd_q + 1'b1;
			if (push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (!push && do_pop)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

FILE: sv/agt_back.sv
// Back section: link moments, torque products, scaling to mNm, rounding and saturation.
// Seven stages, one word per cycle. Depends on agt_pkg.
module agt_back
	import agt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  trig_t   trig,
	input  cfg_t    cfg,
	output logic    done,
	output torque_t torques
);

	logic                  v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, done_q;
	logic [31:0]           wfcf_s1, wglf_s1, g_s1, wbcb_s1;
	logic [32:0]           wslb_s1;
	logic signed [35:0]    p44_s1, p513_s1;
	trig_val_t             s4_s1, c13_s1, c1_s1, c135_s1;
	logic [32:0]           a_s2;
	logic [33:0]           b_s2;
	logic [31:0]           g_s2, g_s3;
	trig_val_t             r1_s2, c13_s2, c1_s2, c135_s2, r3_s3;
	logic signed [35:0]    m_s2;
	logic signed [51:0]    ac13_s3;
	logic signed [50:0]    gr1_s3, pitch_s3, pitch_s4, roll_s4;
	logic signed [52:0]    bc1_s3, bc1_s4;
	logic signed [53:0]    elbow_s4;
	logic signed [Q_W-1:0] q_s5 [0:3];
	logic signed [SCALED_W-1:0] sc_s6 [0:3];
	torque_t               torques_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			v_s6   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= in_valid;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			v_s6   <= v_s5;
			done_q <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		// products of config and trig
		wfcf_s1 <= 32'(cfg.fore_mass) * 32'(cfg.fore_cog);
		wglf_s1 <= 32'(cfg.grip_mass) * 32'(cfg.fore_span);
		g_s1    <= 32'(cfg.grip_mass) * 32'(cfg.grip_cog);
		wbcb_s1 <= 32'(cfg.upper_mass) * 32'(cfg.upper_cog);
		wslb_s1 <= (33'(cfg.fore_mass) + 33'(cfg.grip_mass))
			* 33'(cfg.upper_span);
		p44_s1  <= trig.c13 * trig.c4;
		p513_s1 <= trig.s5 * trig.c13;
		s4_s1   <= trig.s4;
		c13_s1  <= trig.c13;
		c1_s1   <= trig.c1;
		c135_s1 <= trig.c135;

		a_s2    <= 33'(wfcf_s1) + 33'(wglf_s1);
		b_s2    <= 34'(wslb_s1) + 34'(wbcb_s1);
		r1_s2   <= rnd16(p44_s1);
		m_s2    <= rnd16(p513_s1) * (-s4_s1);
		g_s2    <= g_s1;
		c13_s2  <= c13_s1;
		c1_s2   <= c1_s1;
		c135_s2 <= c135_s1;

		ac13_s3  <= $signed({1'b0, a_s2}) * c13_s2;
		gr1_s3   <= $signed({1'b0, g_s2}) * r1_s2;
		bc1_s3   <= $signed({1'b0, b_s2}) * c1_s2;
		pitch_s3 <= $signed({1'b0, g_s2}) * c135_s2;
		r3_s3    <= rnd16(m_s2);
		g_s3     <= g_s2;

		elbow_s4 <= 54'(ac13_s3) + 54'(gr1_s3);
		roll_s4  <= $signed({1'b0, g_s3}) * r3_s3;
		bc1_s4   <= bc1_s3;
		pitch_s4 <= pitch_s3;

		q_s5[0] <= Q_W'(bc1_s4) + Q_W'(elbow_s4);
		q_s5[1] <= Q_W'(elbow_s4);
		q_s5[2] <= Q_W'(roll_s4);
		q_s5[3] <= Q_W'(pitch_s4);

		// times 1360 = 1024 + 256 + 64 + 16
		for (int j = 0; j < 4; j++)
			sc_s6[j] <= (SCALED_W'(q_s5[j]) <<< 10) + (SCALED_W'(q_s5[j]) <<< 8)
				+ (SCALED_W'(q_s5[j]) <<< 6) + (SCALED_W'(q_s5[j]) <<< 4);

		torques_q.shoulder_torque    <= to_mnm(sc_s6[0]);
		torques_q.elbow_torque       <= to_mnm(sc_s6[1]);
		torques_q.wrist_roll_torque  <= to_mnm(sc_s6[2]);
		torques_q.wrist_pitch_torque <= to_mnm(sc_s6[3]);
	end

	assign done    = done_q;
	assign torques = torques_q;

endmodule

FILE: sv/arm_gravity_torque.sv
// Arm gravity torque, top level: config registers, front lookup, queue, back arithmetic.
// A word taken at start passes the front section, the queue and the back section, then appears on torques with done.
// Throughput: one word per cycle; the back section drains the queue every cycle,
// so busy stays low. done is a one-cycle strobe; the receiver cannot stall it.
// Reset: arst_n clears the config registers to zero and empties the pipeline.
// Depends on agt_pkg, agt_front, agt_queue, agt_back.
module arm_gravity_torque
	import agt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  pos_t        positions,
	output logic        done,
	output torque_t     torques,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [15:0] cfg_wdata
);

	cfg_t  cfg_q;
	logic  take, push, nonempty, almost_full;
	trig_t trig_front, trig_queue;

	assign busy = almost_full;
	assign take = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_e'(cfg_addr))
				REG_FORE_MASS:  cfg_q.fore_mass  <= cfg_wdata;
				REG_FORE_COG:   cfg_q.fore_cog   <= cfg_wdata;
				REG_FORE_SPAN:  cfg_q.fore_span  <= cfg_wdata;
				REG_GRIP_MASS:  cfg_q.grip_mass  <= cfg_wdata;
				REG_GRIP_COG:   cfg_q.grip_cog   <= cfg_wdata;
				REG_UPPER_MASS: cfg_q.upper_mass <= cfg_wdata;
				REG_UPPER_COG:  cfg_q.upper_cog  <= cfg_wdata;
				REG_UPPER_SPAN: cfg_q.upper_span <= cfg_wdata;
				default:        cfg_q            <= cfg_q;
			endcase
		end
	end

	agt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.positions (positions),
		.push      (push),
		.trig      (trig_front)
	);

	agt_queue u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.wdata       (trig_front),
		.pop         (1'b1),
		.nonempty    (nonempty),
		.almost_full (almost_full),
		.rdata       (trig_queue)
	);

	agt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (nonempty),
		.trig     (trig_queue),
		.cfg      (cfg_q),
		.done     (done),
		.torques  (torques)
	);

endmodule
